/* rtl/o3d_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package o3d_pkg;

  // Field widths
  localparam int COORD_BITS = 24;
  localparam int ID_BITS    = 16;

  // Datapath widths: differences, multiplier operands, minor and accumulator
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int LO_W   = DIFF_W + 1;
  localparam int OPA_W  = DIFF_W + 2;
  localparam int PROD_W = OPA_W + DIFF_W;
  localparam int MIN_W  = PROD_W;
  localparam int ACC_W  = 3 * DIFF_W + 5;

  // Microprogram and sort sequencing
  localparam int NUM_OPS    = 32;
  localparam int PC_W       = $clog2(NUM_OPS);
  localparam int SORT_STEPS = 6;
  localparam int STEP_W     = $clog2(SORT_STEPS);

  // Point and axis names for the microprogram
  localparam logic [1:0] P0 = 2'd0;
  localparam logic [1:0] P1 = 2'd1;
  localparam logic [1:0] P2 = 2'd2;
  localparam logic [1:0] P3 = 2'd3;
  localparam logic [1:0] AX = 2'd0;
  localparam logic [1:0] AY = 2'd1;
  localparam logic [1:0] AZ = 2'd2;

  typedef enum logic [1:0] {SRC_DIFF, SRC_MLO, SRC_MHI} asrc_t;
  typedef enum logic {BSRC_DIFF, BSRC_ONE} bsrc_t;

  typedef enum logic [2:0] {
    ST_LOAD, ST_SORT, ST_OPND, ST_MUL, ST_ACC, ST_DONE
  } state_t;

  // One micro-op: A * B into the minor register or the accumulator
  typedef struct packed {
    asrc_t      a_src;
    logic [1:0] a_i;
    logic [1:0] a_j;
    logic [1:0] a_k;
    bsrc_t      b_src;
    logic [1:0] b_i;
    logic [1:0] b_j;
    logic [1:0] b_k;
    logic       to_min;
    logic       clr;
    logic       sub;
    logic       shift;
    logic       test;
    logic       neg;
  } uop_t;

  typedef struct packed {
    logic       ready;
    logic       sort_en;
    logic [1:0] sort_j;
    logic       opnd_en;
    logic       mul_en;
    logic       acc_en;
    logic       done;
    logic       pos;
    uop_t       uop;
  } ctl_t;

  // Difference times difference
  function automatic uop_t uop_dd(input logic [1:0] ai, input logic [1:0] aj,
                                  input logic [1:0] ak, input logic [1:0] bi,
                                  input logic [1:0] bj, input logic [1:0] bk,
                                  input logic to_min, input logic clr,
                                  input logic sub, input logic test,
                                  input logic neg);
    uop_t u;
    u.a_src  = SRC_DIFF;
    u.a_i    = ai;
    u.a_j    = aj;
    u.a_k    = ak;
    u.b_src  = BSRC_DIFF;
    u.b_i    = bi;
    u.b_j    = bj;
    u.b_k    = bk;
    u.to_min = to_min;
    u.clr    = clr;
    u.sub    = sub;
    u.shift  = 1'b0;
    u.test   = test;
    u.neg    = neg;
    return u;
  endfunction

  // Half of the stored minor times a difference, into the accumulator
  function automatic uop_t uop_md(input asrc_t src, input logic [1:0] bi,
                                  input logic [1:0] bj, input logic [1:0] bk,
                                  input logic clr, input logic sub,
                                  input logic test);
    uop_t u;
    u.a_src  = src;
    u.a_i    = P0;
    u.a_j    = P0;
    u.a_k    = AX;
    u.b_src  = BSRC_DIFF;
    u.b_i    = bi;
    u.b_j    = bj;
    u.b_k    = bk;
    u.to_min = 1'b0;
    u.clr    = clr;
    u.sub    = sub;
    u.shift  = (src == SRC_MHI);
    u.test   = test;
    u.neg    = 1'b0;
    return u;
  endfunction

  // Sign of a single difference
  function automatic uop_t uop_one(input logic [1:0] ai, input logic [1:0] aj,
                                   input logic [1:0] ak, input logic neg);
    uop_t u;
    u.a_src  = SRC_DIFF;
    u.a_i    = ai;
    u.a_j    = aj;
    u.a_k    = ak;
    u.b_src  = BSRC_ONE;
    u.b_i    = P0;
    u.b_j    = P0;
    u.b_k    = AX;
    u.to_min = 1'b0;
    u.clr    = 1'b1;
    u.sub    = 1'b0;
    u.shift  = 1'b0;
    u.test   = 1'b1;
    u.neg    = neg;
    return u;
  endfunction

  // Determinant by cofactors, then the perturbation cascade
  function automatic uop_t rom(input logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      5'd0:  u = uop_dd(P0, P2, AY, P0, P3, AZ, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
      5'd1:  u = uop_dd(P0, P2, AZ, P0, P3, AY, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
      5'd2:  u = uop_md(SRC_MLO, P0, P1, AX, 1'b1, 1'b0, 1'b0);
      5'd3:  u = uop_md(SRC_MHI, P0, P1, AX, 1'b0, 1'b0, 1'b0);
      5'd4:  u = uop_dd(P0, P2, AX, P0, P3, AZ, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
      5'd5:  u = uop_dd(P0, P2, AZ, P0, P3, AX, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
      5'd6:  u = uop_md(SRC_MLO, P0, P1, AY, 1'b0, 1'b1, 1'b0);
      5'd7:  u = uop_md(SRC_MHI, P0, P1, AY, 1'b0, 1'b1, 1'b0);
      5'd8:  u = uop_dd(P0, P2, AX, P0, P3, AY, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
      5'd9:  u = uop_dd(P0, P2, AY, P0, P3, AX, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
      5'd10: u = uop_md(SRC_MLO, P0, P1, AZ, 1'b0, 1'b0, 1'b0);
      5'd11: u = uop_md(SRC_MHI, P0, P1, AZ, 1'b0, 1'b0, 1'b1);
      5'd12: u = uop_dd(P1, P2, AY, P1, P3, AZ, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
      5'd13: u = uop_dd(P1, P3, AY, P1, P2, AZ, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
      5'd14: u = uop_dd(P0, P2, AY, P0, P3, AZ, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
      5'd15: u = uop_dd(P0, P3, AY, P0, P2, AZ, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
      5'd16: u = uop_dd(P0, P1, AY, P0, P3, AZ, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
      5'd17: u = uop_dd(P0, P3, AY, P0, P1, AZ, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
      5'd18: u = uop_dd(P1, P2, AX, P1, P3, AZ, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
      5'd19: u = uop_dd(P1, P3, AX, P1, P2, AZ, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
      5'd20: u = uop_one(P2, P3, AZ, 1'b1);
      5'd21: u = uop_one(P1, P3, AZ, 1'b0);
      5'd22: u = uop_dd(P0, P2, AX, P0, P3, AZ, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
      5'd23: u = uop_dd(P0, P3, AX, P0, P2, AZ, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
      5'd24: u = uop_one(P0, P3, AZ, 1'b1);
      5'd25: u = uop_dd(P0, P1, AX, P0, P3, AZ, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
      5'd26: u = uop_dd(P0, P3, AX, P0, P1, AZ, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0);
      5'd27: u = uop_dd(P1, P2, AX, P1, P3, AY, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
      5'd28: u = uop_dd(P1, P3, AX, P1, P2, AY, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
      5'd29: u = uop_one(P2, P3, AY, 1'b0);
      5'd30: u = uop_one(P1, P3, AY, 1'b1);
      5'd31: u = uop_one(P2, P3, AX, 1'b1);
      default: u = uop_one(P2, P3, AX, 1'b1);
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

/* rtl/o3d_mac.sv */
`timescale 1ns / 1ps
`default_nettype none
module o3d_mac (
  input  wire logic                          clk,
  input  wire o3d_pkg::ctl_t                 ctl,
  input  wire logic signed [o3d_pkg::DIFF_W-1:0] a_diff,
  input  wire logic signed [o3d_pkg::DIFF_W-1:0] b_diff,
  output logic                               acc_nz,
  output logic                               acc_neg
);
  import o3d_pkg::*;

  logic signed [OPA_W-1:0]  opa_r;
  logic signed [DIFF_W-1:0] opb_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [MIN_W-1:0]  min_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [OPA_W-1:0]  opa_nxt;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  acc_base;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [MIN_W-1:0]  min_base;
  logic signed [MIN_W-1:0]  min_nxt;

  // Pick the A operand: a difference or one half of the stored minor
  always_comb begin
    case (ctl.uop.a_src)
      SRC_DIFF: opa_nxt = {{(OPA_W-DIFF_W){a_diff[DIFF_W-1]}}, a_diff};
      SRC_MLO:  opa_nxt = {1'b0, min_r[LO_W-1:0]};
      SRC_MHI:  opa_nxt = {{(OPA_W-(MIN_W-LO_W)){min_r[MIN_W-1]}}, min_r[MIN_W-1:LO_W]};
      default:  opa_nxt = '0;
    endcase
  end

  // Add or subtract the product, shifted for the upper half
  always_comb begin
    prod_ext = {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    term     = ctl.uop.shift ? (prod_ext <<< LO_W) : prod_ext;
    acc_base = ctl.uop.clr ? '0 : acc_r;
    acc_nxt  = ctl.uop.sub ? (acc_base - term) : (acc_base + term);
    min_base = ctl.uop.clr ? '0 : min_r;
    min_nxt  = ctl.uop.sub ? (min_base - prod_r) : (min_base + prod_r);
  end

  assign acc_nz  = |acc_nxt;
  assign acc_neg = acc_nxt[ACC_W-1];

  // Operand, product and accumulate stages
  always_ff @(posedge clk) begin
    if (ctl.opnd_en) begin
      opa_r <= opa_nxt;
      opb_r <= (ctl.uop.b_src == BSRC_ONE) ? DIFF_W'(1) : b_diff;
    end
    if (ctl.mul_en) begin
      prod_r <= opa_r * opb_r;
    end
    if (ctl.acc_en) begin
      if (ctl.uop.to_min) begin
        min_r <= min_nxt;
      end else begin
        acc_r <= acc_nxt;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/o3d_ctl.sv */
`timescale 1ns / 1ps
`default_nettype none
module o3d_ctl (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   load_last,
  input  wire logic   out_free,
  input  wire logic   acc_nz,
  input  wire logic   acc_neg,
  output o3d_pkg::ctl_t ctl
);
  import o3d_pkg::*;

  localparam logic [PC_W-1:0]   LAST_PC   = PC_W'(NUM_OPS - 1);
  localparam logic [STEP_W-1:0] SORT_LAST = STEP_W'(SORT_STEPS - 1);

  state_t              state_r, state_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic [PC_W-1:0]     pc_r, pc_nxt;
  logic                pos_r, pos_nxt;
  logic [1:0]          sort_j;
  logic                hit;
  logic                last_op;
  uop_t                uop;

  assign uop     = rom(pc_r);
  assign hit     = !uop.to_min && uop.test && acc_nz;
  assign last_op = (pc_r == LAST_PC);

  // Bubble sort pass order: three, then two, then one compare
  always_comb begin
    unique case (step_r)
      3'd0, 3'd3, 3'd5: sort_j = 2'd0;
      3'd1, 3'd4:       sort_j = 2'd1;
      3'd2:             sort_j = 2'd2;
      default:          sort_j = 2'd0;
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: if (load_last) state_nxt = ST_SORT;
      ST_SORT: if (step_r == SORT_LAST) state_nxt = ST_OPND;
      ST_OPND: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = (hit || last_op) ? ST_DONE : ST_OPND;
      ST_DONE: if (out_free) state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  // Advance sort step and program counter, latch the sign
  always_comb begin
    step_nxt = step_r;
    pc_nxt   = pc_r;
    pos_nxt  = pos_r;
    unique case (state_r)
      ST_LOAD: step_nxt = '0;
      ST_SORT: begin
        step_nxt = step_r + 1'b1;
        pc_nxt   = '0;
      end
      ST_ACC: begin
        if (hit) begin
          pos_nxt = (acc_neg == uop.neg);
        end else if (last_op) begin
          pos_nxt = 1'b1;
        end else begin
          pc_nxt = pc_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Drive the datapath strobes
  always_comb begin
    ctl         = '0;
    ctl.uop     = uop;
    ctl.sort_j  = sort_j;
    ctl.pos     = pos_r;
    unique case (state_r)
      ST_LOAD: ctl.ready   = 1'b1;
      ST_SORT: ctl.sort_en = 1'b1;
      ST_OPND: ctl.opnd_en = 1'b1;
      ST_MUL:  ctl.mul_en  = 1'b1;
      ST_ACC:  ctl.acc_en  = 1'b1;
      ST_DONE: ctl.done    = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      step_r  <= '0;
      pc_r    <= '0;
      pos_r   <= 1'b1;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      pc_r    <= pc_nxt;
      pos_r   <= pos_nxt;
    end
  end

  a_opnd_mul: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OPND |=> state_r == ST_MUL)
    else $error("operand stage not followed by multiply");

  a_sort_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SORT |-> step_r <= SORT_LAST)
    else $error("sort step out of range");

  a_pc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OPND || state_r == ST_MUL) |=> $stable(pc_r))
    else $error("program counter moved mid-operation");

  a_done_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_free) |=> state_r == ST_LOAD)
    else $error("result delivered but block not back to loading");

endmodule
`default_nettype wire

/* rtl/orient3d_exact_perturbed.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | vertex_id[16], coord_x/y/z[24] signed
// out_    | output    | out_valid/out_stall| is_left[1], one per four requests
//
// The fourth accepted point request starts the test and the input stalls
// until it finishes. Sorting puts the points in id order, then each of up to
// 32 micro-ops passes the operand, multiply and accumulate states on the one
// shared multiply-accumulate unit; the test ends at the first nonzero test.
// Reset clears the point count and the sequencer. A stalled result holds;
// the next test waits only if its result is ready before the old one leaves.
module orient3d_exact_perturbed (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [o3d_pkg::ID_BITS-1:0]  in_vertex_id,
  input  wire logic signed [o3d_pkg::COORD_BITS-1:0] in_coord_x,
  input  wire logic signed [o3d_pkg::COORD_BITS-1:0] in_coord_y,
  input  wire logic signed [o3d_pkg::COORD_BITS-1:0] in_coord_z,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_is_left
);
  import o3d_pkg::*;

  ctl_t                     ctl;
  logic [1:0]               slot_r;
  logic                     odd_r;
  logic                     out_valid_r;
  logic                     out_is_left_r;
  logic [ID_BITS-1:0]       id_r [4];
  logic [COORD_BITS-1:0]    pt_r [4][3];
  logic                     in_acc;
  logic                     out_free;
  logic                     sort_swap;
  logic [COORD_BITS-1:0]    a_hi, a_lo, b_hi, b_lo;
  logic signed [DIFF_W-1:0] a_diff, b_diff;
  logic                     acc_nz, acc_neg;

  assign in_stall  = !ctl.ready;
  assign in_acc    = in_valid && ctl.ready;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid   = out_valid_r;
  assign out_is_left = out_is_left_r;

  // Compare the pair under sort
  always_comb begin
    sort_swap = 1'b0;
    for (int j = 0; j < 3; j++) begin
      if (ctl.sort_j == 2'(j) && id_r[j] > id_r[j+1]) sort_swap = 1'b1;
    end
  end

  // Store points and swap them into id order
  always_ff @(posedge clk) begin
    if (in_acc) begin
      id_r[slot_r]    <= in_vertex_id;
      pt_r[slot_r][0] <= in_coord_x;
      pt_r[slot_r][1] <= in_coord_y;
      pt_r[slot_r][2] <= in_coord_z;
    end
    for (int j = 0; j < 3; j++) begin
      if (ctl.sort_en && sort_swap && ctl.sort_j == 2'(j)) begin
        id_r[j]   <= id_r[j+1];
        id_r[j+1] <= id_r[j];
        pt_r[j]   <= pt_r[j+1];
        pt_r[j+1] <= pt_r[j];
      end
    end
  end

  // Form the two differences the micro-op asks for
  always_comb begin
    a_hi   = pt_r[ctl.uop.a_j][ctl.uop.a_k];
    a_lo   = pt_r[ctl.uop.a_i][ctl.uop.a_k];
    b_hi   = pt_r[ctl.uop.b_j][ctl.uop.b_k];
    b_lo   = pt_r[ctl.uop.b_i][ctl.uop.b_k];
    a_diff = {a_hi[COORD_BITS-1], a_hi} - {a_lo[COORD_BITS-1], a_lo};
    b_diff = {b_hi[COORD_BITS-1], b_hi} - {b_lo[COORD_BITS-1], b_lo};
  end

  // Count points, track swap parity, hold the result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      odd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) slot_r <= slot_r + 1'b1;
      if (in_acc && slot_r == 2'd3) begin
        odd_r <= 1'b0;
      end else if (ctl.sort_en && sort_swap) begin
        odd_r <= !odd_r;
      end
      if (ctl.done) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.done) out_is_left_r <= (ctl.pos != odd_r);
  end

  o3d_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_last (in_acc && slot_r == 2'd3),
    .out_free  (out_free),
    .acc_nz    (acc_nz),
    .acc_neg   (acc_neg),
    .ctl       (ctl)
  );

  o3d_mac u_mac (
    .clk     (clk),
    .ctl     (ctl),
    .a_diff  (a_diff),
    .b_diff  (b_diff),
    .acc_nz  (acc_nz),
    .acc_neg (acc_neg)
  );

endmodule
`default_nettype wire
